@@ rtl/core/bdli_pkg.sv @@
// Shared types, constants and helpers for the BOM detector and line-feed indexer.
`timescale 1ns / 1ps
`default_nettype none

package bdli_pkg;

	localparam int INDEX_BITS = 32;
	localparam int FIFO_DEPTH = 4;
	localparam int PTR_W      = $clog2(FIFO_DEPTH);
	localparam int CNT_W      = $clog2(FIFO_DEPTH + 1);

	localparam logic [7:0]  BYTE_FF = 8'hFF;
	localparam logic [7:0]  BYTE_FE = 8'hFE;
	localparam logic [7:0]  BYTE_EF = 8'hEF;
	localparam logic [7:0]  BYTE_BB = 8'hBB;
	localparam logic [7:0]  BYTE_BF = 8'hBF;
	localparam logic [15:0] UNIT_LF = 16'h000A;
	localparam logic [15:0] UNIT_CR = 16'h000D;

	typedef logic [INDEX_BITS-1:0] idx_t;

	typedef enum logic [1:0] {
		ENC_UTF8     = 2'd0,
		ENC_UTF8_BOM = 2'd1,
		ENC_UTF16LE  = 2'd2,
		ENC_UTF16BE  = 2'd3
	} enc_t;

	// What the scan stage hands over for one byte.
	typedef struct packed {
		logic        has_ev;
		logic [31:0] ev_index;
		enc_t        ev_enc;
		logic        has_sum;
		enc_t        enc;
		logic [31:0] units;
		logic [31:0] nls;
		logic        crlf;
		idx_t        maxa;
		idx_t        lf_len;
		idx_t        tail;
	} scan_res_t;

	// One queue entry: up to one event and one summary.
	typedef struct packed {
		logic        has_ev;
		logic [31:0] ev_index;
		enc_t        ev_enc;
		logic        has_sum;
		enc_t        enc;
		logic [31:0] units;
		logic [31:0] nls;
		logic [31:0] longest;
		logic        crlf;
	} rec_t;

	function automatic idx_t sat_add(input idx_t v, input logic [1:0] k);
		logic [INDEX_BITS:0] s;
		s = {1'b0, v} + {{(INDEX_BITS-1){1'b0}}, k};
		return s[INDEX_BITS] ? {INDEX_BITS{1'b1}} : s[INDEX_BITS-1:0];
	endfunction

	function automatic logic [31:0] to_out32(input idx_t v);
		logic [63:0] t;
		t = 64'(v);
		return t[31:0];
	endfunction

endpackage

`default_nettype wire

@@ rtl/core/bdli_scan.sv @@
// Input register, mark detection, unit assembly and line tracking state.
`timescale 1ns / 1ps
`default_nettype none

module bdli_scan (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                accept,
	input  wire logic [7:0]          data_byte,
	input  wire logic                is_last,
	output logic                     v_s1,
	output logic                     v_s2,
	output bdli_pkg::scan_res_t      res_s2
);
	import bdli_pkg::*;

	logic [7:0] byte_s1;
	logic       last_s1;

	logic       dec_q;
	enc_t       enc_q;
	logic [1:0] bs_q;
	logic [7:0] h0_q;
	logic [7:0] half_q;
	logic       hv_q;
	idx_t       up_q;
	idx_t       cur_len_q;
	logic       prior_q;
	idx_t       max_q;
	idx_t       pend_q;
	idx_t       lf_q;
	logic       crlf_q;

	logic        feed;
	logic [1:0]  k;
	logic [15:0] unit;
	enc_t        enc_n;
	logic        dec_n;
	logic [1:0]  bs_n;
	logic [7:0]  h0_n;
	logic [7:0]  half_n;
	logic        hv_n;

	idx_t       p1, p2, base, lf_len, len_n, lf_n, maxa;
	logic [1:0] d1, d2;
	logic       prior_eff, is_lf, is_cr, crlf_n, prior_n;

	// Mark decision and unit assembly.
	always_comb begin
		k      = 2'd0;
		feed   = 1'b0;
		unit   = {8'h00, byte_s1};
		enc_n  = enc_q;
		dec_n  = dec_q;
		bs_n   = bs_q;
		h0_n   = h0_q;
		half_n = half_q;
		hv_n   = hv_q;
		if (!dec_q) begin
			case (bs_q)
				2'd0: begin
					if (byte_s1 inside {BYTE_FF, BYTE_FE, BYTE_EF}) begin
						if (last_s1) begin
							k     = 2'd1;
							dec_n = 1'b1;
							enc_n = ENC_UTF8;
						end else begin
							bs_n = 2'd1;
							h0_n = byte_s1;
						end
					end else begin
						dec_n = 1'b1;
						enc_n = ENC_UTF8;
						feed  = 1'b1;
					end
				end
				2'd1: begin
					if (h0_q == BYTE_FF && byte_s1 == BYTE_FE) begin
						dec_n = 1'b1;
						enc_n = ENC_UTF16LE;
						bs_n  = 2'd0;
					end else if (h0_q == BYTE_FE && byte_s1 == BYTE_FF) begin
						dec_n = 1'b1;
						enc_n = ENC_UTF16BE;
						bs_n  = 2'd0;
					end else if (h0_q == BYTE_EF && byte_s1 == BYTE_BB) begin
						if (last_s1) begin
							k     = 2'd2;
							dec_n = 1'b1;
							enc_n = ENC_UTF8;
							bs_n  = 2'd0;
						end else begin
							bs_n = 2'd2;
						end
					end else begin
						k     = 2'd1;
						feed  = 1'b1;
						dec_n = 1'b1;
						enc_n = ENC_UTF8;
						bs_n  = 2'd0;
					end
				end
				default: begin
					// EF BB held
					if (byte_s1 == BYTE_BF) begin
						dec_n = 1'b1;
						enc_n = ENC_UTF8_BOM;
						bs_n  = 2'd0;
					end else begin
						k     = 2'd2;
						feed  = 1'b1;
						dec_n = 1'b1;
						enc_n = ENC_UTF8;
						bs_n  = 2'd0;
					end
				end
			endcase
		end else if (enc_q inside {ENC_UTF8, ENC_UTF8_BOM}) begin
			feed = 1'b1;
		end else if (hv_q) begin
			unit   = (enc_q == ENC_UTF16LE) ? {byte_s1, half_q} : {half_q, byte_s1};
			feed   = 1'b1;
			hv_n   = 1'b0;
			half_n = 8'h00;
		end else begin
			half_n = byte_s1;
			hv_n   = 1'b1;
		end
	end

	// Held bytes are never CR or LF, so they only advance the position.
	always_comb begin
		p1        = sat_add(up_q, k);
		p2        = sat_add(up_q, k + {1'b0, feed});
		d1        = p1[1:0] - up_q[1:0];
		d2        = p2[1:0] - up_q[1:0];
		prior_eff = (k == 2'd0) && prior_q;
		base      = cur_len_q + INDEX_BITS'(d1);
		lf_len    = (prior_eff && base != '0) ? base - INDEX_BITS'(1) : base;
		is_lf     = feed && (unit == UNIT_LF);
		is_cr     = (unit == UNIT_CR);
		len_n     = is_lf ? '0 : cur_len_q + INDEX_BITS'(d2);
		lf_n      = is_lf ? sat_add(lf_q, 2'd1) : lf_q;
		crlf_n    = (is_lf && lf_q == '0) ? prior_eff : crlf_q;
		prior_n   = feed ? is_cr : ((k != 2'd0) ? 1'b0 : prior_q);
		maxa      = (max_q > pend_q) ? max_q : pend_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else begin
			v_s1 <= accept;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			byte_s1 <= data_byte;
			last_s1 <= is_last;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dec_q     <= 1'b0;
			enc_q     <= ENC_UTF8;
			bs_q      <= 2'd0;
			h0_q      <= 8'h00;
			half_q    <= 8'h00;
			hv_q      <= 1'b0;
			up_q      <= '0;
			cur_len_q <= '0;
			prior_q   <= 1'b0;
			max_q     <= '0;
			pend_q    <= '0;
			lf_q      <= '0;
			crlf_q    <= 1'b1;
		end else begin
			// fold the previous line length into the running maximum
			max_q  <= (v_s1 && last_s1) ? '0 : maxa;
			pend_q <= (v_s1 && !last_s1 && is_lf) ? lf_len : '0;
			if (v_s1) begin
				if (last_s1) begin
					dec_q     <= 1'b0;
					enc_q     <= ENC_UTF8;
					bs_q      <= 2'd0;
					h0_q      <= 8'h00;
					half_q    <= 8'h00;
					hv_q      <= 1'b0;
					up_q      <= '0;
					cur_len_q <= '0;
					prior_q   <= 1'b0;
					lf_q      <= '0;
					crlf_q    <= 1'b1;
				end else begin
					dec_q     <= dec_n;
					enc_q     <= enc_n;
					bs_q      <= bs_n;
					h0_q      <= h0_n;
					half_q    <= half_n;
					hv_q      <= hv_n;
					up_q      <= p2;
					cur_len_q <= len_n;
					prior_q   <= prior_n;
					lf_q      <= lf_n;
					crlf_q    <= crlf_n;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else begin
			v_s2 <= v_s1 && (is_lf || last_s1);
		end
	end

	always_ff @(posedge clk) begin
		if (v_s1) begin
			res_s2.has_ev   <= is_lf;
			res_s2.ev_index <= to_out32(p1);
			res_s2.ev_enc   <= enc_n;
			res_s2.has_sum  <= last_s1;
			res_s2.enc      <= enc_n;
			res_s2.units    <= to_out32(p2);
			res_s2.nls      <= to_out32(lf_n);
			res_s2.crlf     <= crlf_n;
			res_s2.maxa     <= maxa;
			res_s2.lf_len   <= is_lf ? lf_len : '0;
			res_s2.tail     <= len_n;
		end
	end

	a_len_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		cur_len_q <= up_q)
		else $error("line length exceeds unit position");

	a_clear_after_last: assert property (@(posedge clk) disable iff (!arst_n)
		(v_s1 && last_s1) |=> (!dec_q && up_q == '0 && lf_q == '0 && crlf_q))
		else $error("state not cleared after final byte");

endmodule

`default_nettype wire

@@ rtl/core/bdli_result.sv @@
// Longest-line resolve, result queue and output sequencing.
`timescale 1ns / 1ps
`default_nettype none

module bdli_result (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 v_s2,
	input  wire bdli_pkg::scan_res_t  res_s2,
	input  wire logic                 result_stall,
	output logic                      result_valid,
	output logic [bdli_pkg::CNT_W-1:0] count,
	output logic                      kind,
	output logic [31:0]               newline_index,
	output logic [1:0]                encoding,
	output logic [31:0]               unit_count,
	output logic [31:0]               newline_count,
	output logic [31:0]               longest_line,
	output logic                      ends_crlf,
	output logic                      last_of_run
);
	import bdli_pkg::*;

	rec_t             fifo_q [FIFO_DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;
	logic             ev_done_q;

	idx_t m1, longest;
	rec_t wr_rec;
	rec_t head;
	logic show_ev, take, pop;

	always_comb begin
		m1      = (res_s2.maxa > res_s2.lf_len) ? res_s2.maxa : res_s2.lf_len;
		longest = (m1 > res_s2.tail) ? m1 : res_s2.tail;
		wr_rec.has_ev   = res_s2.has_ev;
		wr_rec.ev_index = res_s2.ev_index;
		wr_rec.ev_enc   = res_s2.ev_enc;
		wr_rec.has_sum  = res_s2.has_sum;
		wr_rec.enc      = res_s2.enc;
		wr_rec.units    = res_s2.units;
		wr_rec.nls      = res_s2.nls;
		wr_rec.longest  = to_out32(longest);
		wr_rec.crlf     = res_s2.crlf;
	end

	assign head         = fifo_q[rd_ptr_q];
	assign result_valid = (count_q != '0);
	assign count        = count_q;
	assign show_ev      = head.has_ev && !ev_done_q;
	assign take         = result_valid && !result_stall;
	// event first, then summary; pop once the entry's final request goes
	assign pop          = take && (!show_ev || !head.has_sum);

	always_comb begin
		if (show_ev) begin
			kind          = 1'b0;
			newline_index = head.ev_index;
			encoding      = head.ev_enc;
			unit_count    = 32'd0;
			newline_count = 32'd0;
			longest_line  = 32'd0;
			ends_crlf     = 1'b0;
			last_of_run   = !head.has_sum;
		end else begin
			kind          = 1'b1;
			newline_index = 32'd0;
			encoding      = head.enc;
			unit_count    = head.units;
			newline_count = head.nls;
			longest_line  = head.longest;
			ends_crlf     = head.crlf;
			last_of_run   = 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (v_s2) begin
			fifo_q[wr_ptr_q] <= wr_rec;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q  <= '0;
			rd_ptr_q  <= '0;
			count_q   <= '0;
			ev_done_q <= 1'b0;
		end else begin
			if (v_s2) begin
				wr_ptr_q <= wr_ptr_q + PTR_W'(1);
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + PTR_W'(1);
			end
			count_q <= count_q + CNT_W'(v_s2) - CNT_W'(pop);
			if (take) begin
				ev_done_q <= !pop;
			end
		end
	end

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		v_s2 |-> (count_q < CNT_W'(FIFO_DEPTH)))
		else $error("result queue written while full");

	a_split_entry: assert property (@(posedge clk) disable iff (!arst_n)
		ev_done_q |-> (count_q != '0 && head.has_ev && head.has_sum))
		else $error("event marked sent on an entry without a pending summary");

endmodule

`default_nettype wire

@@ rtl/core/bom_detect_line_indexer.sv @@
// Top level of the byte order mark detector and line-feed indexer.
// Takes one file byte per clock while byte_stall is low, and reports every line-feed unit
// with its unit index, then a summary on the final byte (encoding, unit count, line-feed
// count, longest line, CRLF flag); after the summary the block starts over on a new file.
// A byte that yields both an event and a summary occupies the result port for both, and the
// 4-entry result queue absorbs that until the input is stalled. The first result of an
// accepted byte passes through the input register, the scan register and the queue.
// Counters saturate at all ones of the index width. No clearing pass after reset.
`timescale 1ns / 1ps
`default_nettype none

module bom_detect_line_indexer (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        byte_valid,
	output logic             byte_stall,
	input  wire logic [7:0]  data_byte,
	input  wire logic        is_last,
	output logic             result_valid,
	input  wire logic        result_stall,
	output logic             kind,
	output logic [31:0]      newline_index,
	output logic [1:0]       encoding,
	output logic [31:0]      unit_count,
	output logic [31:0]      newline_count,
	output logic [31:0]      longest_line,
	output logic             ends_crlf,
	output logic             last_of_run
);
	import bdli_pkg::*;

	logic             accept;
	logic             v_s1;
	logic             v_s2;
	scan_res_t        res_s2;
	logic [CNT_W-1:0] count;
	logic [CNT_W:0]   load;

	// reserve a queue entry for every request still in the pipe
	assign load       = {1'b0, count} + (CNT_W+1)'(v_s1) + (CNT_W+1)'(v_s2);
	assign byte_stall = (load >= (CNT_W+1)'(FIFO_DEPTH));
	assign accept     = byte_valid && !byte_stall;

	bdli_scan u_scan (
		.clk       (clk),
		.arst_n    (arst_n),
		.accept    (accept),
		.data_byte (data_byte),
		.is_last   (is_last),
		.v_s1      (v_s1),
		.v_s2      (v_s2),
		.res_s2    (res_s2)
	);

	bdli_result u_result (
		.clk           (clk),
		.arst_n        (arst_n),
		.v_s2          (v_s2),
		.res_s2        (res_s2),
		.result_stall  (result_stall),
		.result_valid  (result_valid),
		.count         (count),
		.kind          (kind),
		.newline_index (newline_index),
		.encoding      (encoding),
		.unit_count    (unit_count),
		.newline_count (newline_count),
		.longest_line  (longest_line),
		.ends_crlf     (ends_crlf),
		.last_of_run   (last_of_run)
	);

endmodule

`default_nettype wire
